// ----- sv/cdq_pkg.sv -----
// cdq_pkg: shared types and constants for the crop, downsample and quantise block.
// Used by the channel interfaces and by the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int PIXEL_W    = 8;
  localparam int VALUE_W    = 8;
  localparam int SCALE_W    = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  typedef logic [PIXEL_W-1:0]        pixel_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [SCALE_W-1:0]        scale_t;

  // register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUANT_MODE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INV_SCALE  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_Q_OFFSET   = 3'd4;

  localparam logic QMODE_LEGACY = 1'b0;
  localparam logic QMODE_AFFINE = 1'b1;

  localparam logic [7:0] OUT_SIZE_RESET = 8'd96;

  typedef struct packed {
    value_t value;
    logic   frame_last;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/cdq_if.sv -----
// cdq_if: valid/ready channel interfaces for source pixels and quantised results.
// Depends on cdq_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none

interface cdq_pixel_if;
  logic            valid;
  logic            ready;
  cdq_pkg::pixel_t pixel;
  logic            frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface cdq_result_if;
  logic            valid;
  logic            ready;
  cdq_pkg::value_t value;
  logic            frame_last;

  modport source (output valid, value, frame_last, input ready);
  modport sink   (input valid, value, frame_last, output ready);
endinterface

`default_nettype wire

// ----- sv/crop_downsample_quantize_unit.sv -----
// crop_downsample_quantize_unit: crop centred in x from row 0, nearest-neighbour downscale, int8 quantise.
// Depends on cdq_pkg and the channel interfaces in cdq_if.
//
// Usage:
//   in_stream carries raw 8-bit pixels in raster order; frame_start on the first
//   pixel of a frame restarts all position counters. out_stream carries one int8
//   value per kept pixel, frame_last on output pixel (W-1, H-1).
//   Registers (APB, byte address 4*i): out_width, out_height, quant_mode,
//   inv_scale (Q8.16), q_offset (signed int8 offset). Write them between transfers only.
// Timing:
//   One pixel is taken every cycle. Position logic and the 8x24 multiply plus clamp form
//   a single stage ahead of an output register and a skid entry. A kept pixel appears on
//   out_stream the cycle after its transfer unless the output register keeps an unread
//   result; it then waits in the skid entry. Pixels keep flowing while the receiver stalls
//   until a second kept pixel waits; in_stream.ready drops only when both hold a result.
// Reset:
//   Synchronous, active low. Registers return to 96x96 legacy mode, counters
//   clear, both result entries empty. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module crop_downsample_quantize_unit #(
  parameter int SRC_WIDTH = 176,
  parameter int CROP_SIDE = 144
) (
  input  wire                             clk,
  input  wire                             rst_n,
  cdq_pixel_if.sink                       in_stream,
  cdq_result_if.source                    out_stream,
  input  wire                             psel,
  input  wire                             penable,
  input  wire                             pwrite,
  input  wire [cdq_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire [cdq_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [cdq_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int CROP_X0 = (SRC_WIDTH >= CROP_SIDE) ? ((SRC_WIDTH - CROP_SIDE) / 2) : 0;
  localparam logic [8:0] X0 = 9'(CROP_X0);
  localparam logic [7:0] SIDE = 8'(CROP_SIDE);
  localparam logic [7:0] LAST_COL = 8'(SRC_WIDTH - 1);

  // CROP_SIDE / v and CROP_SIDE % v for every nonzero register value (entry 0 is zero)
  logic [7:0] div_q [256];
  logic [7:0] div_r [256];
  assign div_q[0] = '0;
  assign div_r[0] = '0;
  for (genvar V = 1; V < 256; V++) begin : g_div
    assign div_q[V] = 8'(CROP_SIDE / V);
    assign div_r[V] = 8'(CROP_SIDE % V);
  end

  // ---------------- configuration ----------------
  logic [7:0]      out_width_r, out_height_r;
  logic            quant_mode_r;
  cdq_pkg::scale_t inv_scale_r;
  logic [7:0]      q_offset_r;

  logic                          cfg_wr;
  logic [cdq_pkg::REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[cdq_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_width_r  <= cdq_pkg::OUT_SIZE_RESET;
      out_height_r <= cdq_pkg::OUT_SIZE_RESET;
      quant_mode_r <= cdq_pkg::QMODE_LEGACY;
      inv_scale_r  <= '0;
      q_offset_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cdq_pkg::REG_OUT_WIDTH:  out_width_r  <= pwdata[7:0];
        cdq_pkg::REG_OUT_HEIGHT: out_height_r <= pwdata[7:0];
        cdq_pkg::REG_QUANT_MODE: quant_mode_r <= pwdata[0];
        cdq_pkg::REG_INV_SCALE:  inv_scale_r  <= pwdata[cdq_pkg::SCALE_W-1:0];
        cdq_pkg::REG_Q_OFFSET:   q_offset_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cdq_pkg::REG_OUT_WIDTH:  prdata = {24'd0, out_width_r};
      cdq_pkg::REG_OUT_HEIGHT: prdata = {24'd0, out_height_r};
      cdq_pkg::REG_QUANT_MODE: prdata = {31'd0, quant_mode_r};
      cdq_pkg::REG_INV_SCALE:  prdata = {8'd0, inv_scale_r};
      cdq_pkg::REG_Q_OFFSET:   prdata = {24'd0, q_offset_r};
      default:                 prdata = '0;
    endcase
  end

  // effective sizes: 0 reads as 1, above the crop side saturates
  logic [7:0] w, h;
  always_comb begin
    w = out_width_r;
    if (out_width_r == 8'd0) w = 8'd1;
    else if (out_width_r > SIDE) w = SIDE;
    h = out_height_r;
    if (out_height_r == 8'd0) h = 8'd1;
    else if (out_height_r > SIDE) h = SIDE;
  end

  // ---------------- position state ----------------
  logic [7:0] src_column_r, src_row_r, out_column_r, out_row_r;
  logic [8:0] target_column_r, target_row_r;
  logic [7:0] column_remainder_r, row_remainder_r;

  logic [7:0] src_column_nxt, src_row_nxt, out_column_nxt, out_row_nxt;
  logic [8:0] target_column_nxt, target_row_nxt;
  logic [7:0] column_remainder_nxt, row_remainder_nxt;

  logic       in_fire, fs, hit, last_px;
  logic [7:0] e_scol, e_srow, e_ocol, e_orow, e_crem, e_rrem;
  logic [8:0] e_tcol, e_trow;
  logic [8:0] crem_sum, rrem_sum;
  logic       ccarry, rcarry;
  logic [8:0] tcol_adv, trow_adv;
  logic [7:0] crem_adv, rrem_adv;

  assign in_fire = in_stream.valid && in_stream.ready;
  assign fs      = in_stream.frame_start;

  always_comb begin
    // frame_start restarts the counters before this pixel is looked at
    e_scol = fs ? 8'd0 : src_column_r;
    e_srow = fs ? 8'd0 : src_row_r;
    e_ocol = fs ? 8'd0 : out_column_r;
    e_orow = fs ? 8'd0 : out_row_r;
    e_tcol = fs ? X0   : target_column_r;
    e_trow = fs ? 9'd0 : target_row_r;
    e_crem = fs ? 8'd0 : column_remainder_r;
    e_rrem = fs ? 8'd0 : row_remainder_r;

    hit = (e_orow < h) && ({1'b0, e_srow} == e_trow) && ({1'b0, e_scol} == e_tcol)
          && (e_ocol < w);
    last_px = (e_ocol == w - 8'd1) && (e_orow == h - 8'd1);

    crem_sum = {1'b0, e_crem} + {1'b0, div_r[w]};
    ccarry   = crem_sum >= {1'b0, w};
    crem_adv = ccarry ? 8'(crem_sum - {1'b0, w}) : crem_sum[7:0];
    tcol_adv = e_tcol + {1'b0, div_q[w]} + {8'd0, ccarry};

    rrem_sum = {1'b0, e_rrem} + {1'b0, div_r[h]};
    rcarry   = rrem_sum >= {1'b0, h};
    rrem_adv = rcarry ? 8'(rrem_sum - {1'b0, h}) : rrem_sum[7:0];
    trow_adv = e_trow + {1'b0, div_q[h]} + {8'd0, rcarry};

    out_column_nxt       = hit ? e_ocol + 8'd1 : e_ocol;
    target_column_nxt    = hit ? tcol_adv : e_tcol;
    column_remainder_nxt = hit ? crem_adv : e_crem;
    out_row_nxt          = e_orow;
    target_row_nxt       = e_trow;
    row_remainder_nxt    = e_rrem;
    src_row_nxt          = e_srow;
    src_column_nxt       = e_scol + 8'd1;

    if (e_scol >= LAST_COL) begin
      // end of a source row: move to the next output row if this one was used
      if ((e_orow < h) && ({1'b0, e_srow} == e_trow)) begin
        out_row_nxt          = e_orow + 8'd1;
        out_column_nxt       = 8'd0;
        target_column_nxt    = X0;
        column_remainder_nxt = 8'd0;
        target_row_nxt       = trow_adv;
        row_remainder_nxt    = rrem_adv;
      end
      src_column_nxt = 8'd0;
      if (e_srow != 8'hFF) src_row_nxt = e_srow + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_column_r       <= '0;
      src_row_r          <= '0;
      out_column_r       <= '0;
      out_row_r          <= '0;
      target_column_r    <= X0;
      target_row_r       <= '0;
      column_remainder_r <= '0;
      row_remainder_r    <= '0;
    end else if (in_fire) begin
      src_column_r       <= src_column_nxt;
      src_row_r          <= src_row_nxt;
      out_column_r       <= out_column_nxt;
      out_row_r          <= out_row_nxt;
      target_column_r    <= target_column_nxt;
      target_row_r       <= target_row_nxt;
      column_remainder_r <= column_remainder_nxt;
      row_remainder_r    <= row_remainder_nxt;
    end
  end

  // ---------------- quantiser ----------------
  cdq_pkg::pixel_t     p;
  logic [7:0]          dmag;
  logic                neg;
  logic [31:0]         prod;
  logic [32:0]         rsum;
  logic [15:0]         rq;
  logic signed [17:0]  sr, sz;
  cdq_pkg::value_t     qv;

  always_comb begin
    p = in_stream.pixel;
    // |2p - 255| is always odd
    dmag = {p[7] ? p[6:0] : ~p[6:0], 1'b1};
    neg  = !p[7];
    prod = {24'd0, dmag} * {8'd0, inv_scale_r};
    rsum = {1'b0, prod} + 33'd65536;
    rq   = rsum[32:17];
    sr   = neg ? -$signed({2'b00, rq}) : $signed({2'b00, rq});
    sz   = sr + 18'(signed'(q_offset_r));
    if (quant_mode_r == cdq_pkg::QMODE_LEGACY) qv = {~p[7], p[6:0]};
    else if (sz < -18'sd128) qv = -8'sd128;
    else if (sz > 18'sd127) qv = 8'sd127;
    else qv = sz[7:0];
  end

  // ---------------- result register and skid entry ----------------
  cdq_pkg::res_t main_r, skid_r, res_new;
  logic          main_v_r, skid_v_r, push, pop;

  assign res_new          = '{value: qv, frame_last: last_px};
  assign push             = in_fire && hit;
  assign pop              = out_stream.valid && out_stream.ready;
  assign in_stream.ready  = !skid_v_r;
  assign out_stream.valid = main_v_r;
  assign out_stream.value = main_r.value;
  assign out_stream.frame_last = main_r.frame_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= 1'b0;
      end else if (!push) begin
        main_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_v_r) main_v_r <= 1'b1;
      else skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) main_r <= skid_r;
      else if (push) main_r <= res_new;
    end else if (push) begin
      if (!main_v_r) main_r <= res_new;
      else skid_r <= res_new;
    end
  end

`ifndef SYNTH
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry held without output entry");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_v_r)
    else $error("result pushed with both entries full");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && fs) |=> (src_column_r == 8'd1 && src_row_r == 8'd0))
    else $error("frame start did not restart source position");

  a_row_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !fs) |=> (src_row_r >= $past(src_row_r)))
    else $error("source row went backwards within a frame");
`endif

endmodule

`default_nettype wire
